// ----- rtl/bba_pkg.sv -----
// Shared constants and controller/datapath signal groups for the buddy allocator.
package bba_pkg;

    localparam int WORD_W     = 32;
    localparam int WORD_IDX_W = 5;
    localparam int HDR_BYTES  = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       clr_wr;
        logic       clr_inc;
        logic       rd;
        logic       sel_scan;
        logic       lvl_load_k;
        logic       lvl_load_leaf;
        logic       lvl_dec;
        logic       lvl_inc;
        logic       row_clr;
        logic       row_inc;
        logic       off_found;
        logic       off_merge;
        logic       first_set;
        logic       first_clr;
        logic       wr_walk;
        logic       wr_merge;
        logic       res_load;
        logic       res_addr_sel;
        logic [1:0] res_status;
    } dp_ctrl_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic too_big;
        logic oob;
        logic hit;
        logic last_row;
        logic lvl_zero;
        logic lvl_at_k;
        logic misaligned;
        logic busy_hit;
        logic sib_free;
        logic out_full;
    } dp_stat_t;

endpackage

// ----- rtl/bba_ifs.sv -----
// Channel interfaces: request, response and configuration write.
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [20:0] req_size;
    logic [31:0] user_addr;
    modport source (output valid, cmd, req_size, user_addr, input ready);
    modport sink (input valid, cmd, req_size, user_addr, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] alloc_addr;
    modport source (output valid, status, alloc_addr, input ready);
    modport sink (input valid, status, alloc_addr, output ready);
endinterface

interface bba_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] memory_base;
    modport source (output valid, memory_base, input ready);
    modport sink (input valid, memory_base, output ready);
endinterface

// ----- rtl/bba_datapath.sv -----
// Datapath: bitmap memory, level/offset registers, size decode and result register.
module bba_datapath #(
    parameter int MIN_ORDER = 10,
    parameter int MAX_ORDER = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  logic               in_cmd,
    input  logic [20:0]        in_req_size,
    input  logic [31:0]        in_user_addr,
    input  bba_pkg::dp_ctrl_t  ctrl,
    output bba_pkg::dp_stat_t  stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [31:0]        out_alloc_addr
);

    localparam int LEVELS = MAX_ORDER - MIN_ORDER + 1;
    localparam int LW     = $clog2(LEVELS);
    localparam int PW     = (LEVELS - 1 > 6) ? LEVELS - 1 : 6;
    localparam int RW     = PW - bba_pkg::WORD_IDX_W;
    localparam int AW     = LW + RW;
    localparam int DEPTH  = 1 << AW;
    localparam int OW     = MAX_ORDER;
    localparam int SW     = $clog2(MAX_ORDER + 1);
    localparam int NW     = (MAX_ORDER + 2 > 22) ? MAX_ORDER + 2 : 22;
    localparam int MW     = 2 * bba_pkg::WORD_W;

    // word layout: upper half busy bits, lower half free bits
    logic [MW-1:0]     map_mem [DEPTH];
    logic [MW-1:0]     rd_data_reg;

    logic [31:0]       base_reg;
    logic              cmd_reg;
    logic [LW-1:0]     kl_reg;
    logic              too_big_reg;
    logic              oob_reg;
    logic [OW-1:0]     off_reg;
    logic [OW-1:0]     off_next;
    logic [LW-1:0]     lvl_reg;
    logic [LW-1:0]     lvl_next;
    logic [RW-1:0]     row_reg;
    logic [RW-1:0]     row_next;
    logic              first_reg;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [31:0]       addr_reg;

    logic [NW-1:0]     need;
    logic [SW-1:0]     k_ord;
    logic              big;
    logic [31:0]       off_full;
    logic [SW-1:0]     order;
    logic [OW-1:0]     pos_wide;
    logic [PW-1:0]     pos;
    logic [4:0]        bidx;
    logic [AW-1:0]     node_addr;
    logic [AW-1:0]     rd_addr;
    logic [31:0]       free_w;
    logic [31:0]       busy_w;
    logic [4:0]        lsb;
    logic [PW-1:0]     found_pos;
    logic [OW-1:0]     align_mask;
    logic [PW:0]       lr_tmp;
    logic [31:0]       wf;
    logic [31:0]       wb;
    logic              we;
    logic [AW-1:0]     wa;
    logic [MW-1:0]     wd;

    // size decode: smallest order whose block holds size plus header
    assign need = NW'(in_req_size) + NW'(bba_pkg::HDR_BYTES);
    always_comb
    begin
        k_ord = SW'(MAX_ORDER);
        for (int o = MAX_ORDER; o >= MIN_ORDER; o--)
        begin
            if ((NW'(1) << o) >= need)
                k_ord = SW'(o);
        end
    end
    assign big      = need > (NW'(1) << MAX_ORDER);
    assign off_full = in_user_addr - 32'(bba_pkg::HDR_BYTES) - base_reg;

    assign order      = SW'(MAX_ORDER) - SW'(lvl_reg);
    assign pos_wide   = off_reg >> order;
    assign pos        = pos_wide[PW-1:0];
    assign bidx       = pos[4:0];
    assign node_addr  = {lvl_reg, pos[PW-1:5]};
    assign rd_addr    = ctrl.sel_scan ? {lvl_reg, row_reg} : node_addr;
    assign free_w     = rd_data_reg[31:0];
    assign busy_w     = rd_data_reg[MW-1:32];
    assign found_pos  = {row_reg, lsb};
    assign align_mask = (OW'(1) << order) - OW'(1);
    assign lr_tmp     = ((PW+1)'(1) << lvl_reg) - (PW+1)'(1);

    always_comb
    begin
        lsb = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (free_w[i])
                lsb = 5'(i);
        end
    end

    assign stat.clr_done   = &clr_reg;
    assign stat.is_free    = cmd_reg == bba_pkg::CMD_FREE;
    assign stat.too_big    = too_big_reg;
    assign stat.oob        = oob_reg;
    assign stat.hit        = |free_w;
    assign stat.last_row   = row_reg == lr_tmp[PW-1:5];
    assign stat.lvl_zero   = lvl_reg == '0;
    assign stat.lvl_at_k   = lvl_reg == kl_reg;
    assign stat.misaligned = |(off_reg & align_mask);
    assign stat.busy_hit   = busy_w[bidx];
    assign stat.sib_free   = free_w[bidx ^ 5'd1];
    assign stat.out_full   = out_valid_reg;

    // read-modify-write data for split walk and merge
    always_comb
    begin
        wf = free_w;
        wb = busy_w;
        if (ctrl.wr_walk)
        begin
            if (first_reg)
                wf[bidx] = 1'b0;
            else
                wf[bidx | 5'd1] = 1'b1;
            if (lvl_reg == kl_reg)
                wb[bidx] = 1'b1;
        end
        else
        begin
            wb[bidx] = 1'b0;
            if (lvl_reg != '0 && free_w[bidx ^ 5'd1])
                wf[bidx ^ 5'd1] = 1'b0;
            else
                wf[bidx] = 1'b1;
        end
    end

    assign we = ctrl.clr_wr | ctrl.wr_walk | ctrl.wr_merge;
    assign wa = ctrl.clr_wr ? clr_reg : node_addr;
    assign wd = ctrl.clr_wr ? ((clr_reg == '0) ? MW'(1) : '0) : {wb, wf};

    always_ff @(posedge clk)
    begin
        if (we)
            map_mem[wa] <= wd;
        if (ctrl.rd)
            rd_data_reg <= map_mem[rd_addr];
    end

    always_comb
    begin
        lvl_next = lvl_reg;
        if (ctrl.lvl_load_k)
            lvl_next = kl_reg;
        else if (ctrl.lvl_load_leaf)
            lvl_next = LW'(LEVELS - 1);
        else if (ctrl.lvl_dec)
            lvl_next = lvl_reg - LW'(1);
        else if (ctrl.lvl_inc)
            lvl_next = lvl_reg + LW'(1);

        row_next = row_reg;
        if (ctrl.row_clr)
            row_next = '0;
        else if (ctrl.row_inc)
            row_next = row_reg + RW'(1);

        off_next = off_reg;
        if (ctrl.accept)
            off_next = off_full[OW-1:0];
        else if (ctrl.off_found)
            off_next = OW'(found_pos) << order;
        else if (ctrl.off_merge)
            off_next = off_reg & ~(OW'(1) << order);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
        row_reg <= row_next;
        off_reg <= off_next;
        if (ctrl.accept)
        begin
            cmd_reg     <= in_cmd;
            kl_reg      <= LW'(SW'(MAX_ORDER) - k_ord);
            too_big_reg <= big;
            oob_reg     <= |off_full[31:OW];
        end
        if (ctrl.first_set)
            first_reg <= 1'b1;
        else if (ctrl.first_clr)
            first_reg <= 1'b0;
        if (ctrl.res_load)
        begin
            status_reg <= ctrl.res_status;
            addr_reg   <= ctrl.res_addr_sel
                          ? base_reg + 32'(off_reg) + 32'(bba_pkg::HDR_BYTES) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                base_reg <= cfg_data;
            if (ctrl.clr_inc)
                clr_reg <= clr_reg + AW'(1);
            if (ctrl.res_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_alloc_addr = addr_reg;

endmodule

// ----- rtl/bba_ctrl.sv -----
// Controller: sequences clearing pass, free-block search, split walk and merge.
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bba_pkg::dp_stat_t  stat,
    output bba_pkg::dp_ctrl_t  ctrl
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_A_RD  = 4'd3;
    localparam logic [3:0] S_A_CHK = 4'd4;
    localparam logic [3:0] S_W_RD  = 4'd5;
    localparam logic [3:0] S_W_WR  = 4'd6;
    localparam logic [3:0] S_F_RD  = 4'd7;
    localparam logic [3:0] S_F_CHK = 4'd8;
    localparam logic [3:0] S_M_RD  = 4'd9;
    localparam logic [3:0] S_M_WR  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] code_reg;
    logic [1:0] code_next;
    logic       asel_reg;
    logic       asel_next;

    always_comb
    begin
        ctrl       = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        code_next  = code_reg;
        asel_next  = asel_reg;
        ctrl.res_status   = code_reg;
        ctrl.res_addr_sel = asel_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl.clr_wr  = 1'b1;
                ctrl.clr_inc = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                asel_next = 1'b0;
                if (!stat.is_free)
                begin
                    if (stat.too_big)
                    begin
                        code_next  = bba_pkg::ST_NOSPACE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctrl.lvl_load_k = 1'b1;
                        ctrl.row_clr    = 1'b1;
                        state_next      = S_A_RD;
                    end
                end
                else if (stat.oob)
                begin
                    code_next  = bba_pkg::ST_NOTALLOC;
                    state_next = S_FIN;
                end
                else
                begin
                    ctrl.lvl_load_leaf = 1'b1;
                    state_next         = S_F_RD;
                end
            end
            S_A_RD:
            begin
                ctrl.rd       = 1'b1;
                ctrl.sel_scan = 1'b1;
                state_next    = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (stat.hit)
                begin
                    ctrl.off_found = 1'b1;
                    ctrl.first_set = 1'b1;
                    state_next     = S_W_RD;
                end
                else if (stat.last_row)
                begin
                    if (stat.lvl_zero)
                    begin
                        code_next  = bba_pkg::ST_NOSPACE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ctrl.lvl_dec = 1'b1;
                        ctrl.row_clr = 1'b1;
                        state_next   = S_A_RD;
                    end
                end
                else
                begin
                    ctrl.row_inc = 1'b1;
                    state_next   = S_A_RD;
                end
            end
            S_W_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_W_WR;
            end
            S_W_WR:
            begin
                ctrl.wr_walk   = 1'b1;
                ctrl.first_clr = 1'b1;
                if (stat.lvl_at_k)
                begin
                    code_next  = bba_pkg::ST_DONE;
                    asel_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ctrl.lvl_inc = 1'b1;
                    state_next   = S_W_RD;
                end
            end
            S_F_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (stat.misaligned)
                begin
                    code_next  = bba_pkg::ST_NOTALLOC;
                    state_next = S_FIN;
                end
                else if (stat.busy_hit)
                    state_next = S_M_RD;
                else if (stat.lvl_zero)
                begin
                    code_next  = bba_pkg::ST_NOTALLOC;
                    state_next = S_FIN;
                end
                else
                begin
                    ctrl.lvl_dec = 1'b1;
                    state_next   = S_F_RD;
                end
            end
            S_M_RD:
            begin
                ctrl.rd    = 1'b1;
                state_next = S_M_WR;
            end
            S_M_WR:
            begin
                ctrl.wr_merge = 1'b1;
                if (!stat.lvl_zero && stat.sib_free)
                begin
                    ctrl.off_merge = 1'b1;
                    ctrl.lvl_dec   = 1'b1;
                    state_next     = S_M_RD;
                end
                else
                begin
                    code_next  = bba_pkg::ST_DONE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_full)
                begin
                    ctrl.res_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= bba_pkg::ST_DONE;
            asel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            asel_reg  <= asel_next;
        end
    end

    a_load_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.res_load |-> !stat.out_full)
        else $error("result loaded over a pending item");
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("item accepted during clearing pass");
    a_merge_rmw: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.wr_merge |-> $past(ctrl.rd))
        else $error("merge write without preceding read");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.lvl_inc |-> !stat.lvl_at_k)
        else $error("split walk past target level");
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> state_reg == S_START)
        else $error("accept did not start a request");

endmodule

// ----- rtl/buddy_block_allocator_core.sv -----
// Allocate scans the bitmap rows of the target level, then of each level nearer the root,
// and splits the block found down level by level; free probes levels from the leaf level
// up and merges while the buddy is free; a request may be rejected at the start. One item at
// a time; the bitmap memory port (one read, one write per cycle) sets the pace.
// The next item is accepted while a result waits in the output register.
// After reset a clearing pass initializes the bitmaps; no item is accepted until it ends.
// Config writes are always taken.
module buddy_block_allocator_core #(
    parameter int MIN_ORDER = 10,
    parameter int MAX_ORDER = 20
) (
    input logic    clk,
    input logic    rst_n,
    bba_cfg_if.sink cfg,
    bba_req_if.sink req,
    bba_rsp_if.source rsp
);

    bba_pkg::dp_ctrl_t ctrl;
    bba_pkg::dp_stat_t stat;
    logic              in_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bba_datapath #(
        .MIN_ORDER (MIN_ORDER),
        .MAX_ORDER (MAX_ORDER)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg.valid),
        .cfg_data       (cfg.memory_base),
        .in_cmd         (req.cmd),
        .in_req_size    (req.req_size),
        .in_user_addr   (req.user_addr),
        .ctrl           (ctrl),
        .stat           (stat),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_alloc_addr (rsp.alloc_addr)
    );

endmodule
